// ===== src/psds_pkg.sv =====
// Shared constants, widths and the CORDIC angle table for the phase-shift depth step.
`default_nettype none
package psds_pkg;

  localparam int unsigned SAMPLE_WIDTH_DEF  = 16;
  localparam int unsigned CORDIC_STAGES_DEF = 16;

  localparam int unsigned MAX_GRID_WIDTH = 4096;
  localparam int unsigned MAX_FREQ_BINS  = 1024;

  localparam int unsigned K_W    = 12;
  localparam int unsigned W_W    = 10;
  localparam int unsigned GW_W   = 13;
  localparam int unsigned CFG_W  = 32;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned WSQ_W  = 2 * W_W;
  localparam int unsigned KSQ_W  = 2 * K_W;
  localparam int unsigned ARG_W  = CFG_W + WSQ_W;
  localparam int unsigned ROOT_W = ARG_W / 2;
  localparam int unsigned REM_W  = ROOT_W + 2;
  localparam int unsigned PH_W   = 32;
  localparam int unsigned CW     = 34;
  localparam int unsigned FRAC_SHIFT = 30;

  localparam logic [CW-1:0] CORDIC_GAIN = CW'(652032874);

  localparam logic [IDX_W-1:0] REG_DEPTH_SCALE = 2'd0;
  localparam logic [IDX_W-1:0] REG_PHASE_SCALE = 2'd1;
  localparam logic [IDX_W-1:0] REG_GRID_WIDTH  = 2'd2;

  localparam logic [CFG_W-1:0] DEPTH_SCALE_RST = 32'd65536;
  localparam logic [CFG_W-1:0] PHASE_SCALE_RST = 32'd0;
  localparam logic [GW_W-1:0]  GRID_WIDTH_RST  = 13'd256;

  // atan(2^-i) in Q0.32 turns
  function automatic logic [PH_W-1:0] rot_turn(input int unsigned i);
    logic [PH_W-1:0] r;
    case (i)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458907;
      3:  r = 32'd85004756;
      4:  r = 32'd42667331;
      5:  r = 32'd21354465;
      6:  r = 32'd10679838;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      24: r = 32'd41;
      25: r = 32'd20;
      26: r = 32'd10;
      27: r = 32'd5;
      28: r = 32'd3;
      29: r = 32'd1;
      30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/phase_shift_depth_step_top.sv =====
// Top level of the phase-shift depth step: folding, argument, root, phase, rotation.
//
// Phase-shift depth step. Each input transaction carries one complex f-k sample with
// its wavenumber and frequency bins; each produces exactly one output transaction,
// in order. The block is fully pipelined: one sample per clock while the output is
// not stalled. Its stages are folding and squares, argument, a one-bit-per-stage
// square root, phase multiply, the CORDIC chain and the complex multiply with
// rounding. A stalled output freezes the whole pipeline;
// in_stall_o then rises. Registers are written through the cfg port, which is
// always ready, and must only be changed while the pipeline is empty.
`default_nettype none
module phase_shift_depth_step_top #(
  parameter int unsigned SAMPLE_WIDTH  = psds_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned CORDIC_STAGES = psds_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [psds_pkg::IDX_W-1:0]    cfg_index_i,
  input  wire logic [psds_pkg::CFG_W-1:0]    cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [psds_pkg::K_W-1:0]      wavenumber_index_i,
  input  wire logic [psds_pkg::W_W-1:0]      frequency_index_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_re_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_im_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]     result_re_o,
  output logic signed [SAMPLE_WIDTH-1:0]     result_im_o,
  output logic                               evanescent_o
);
  import psds_pkg::*;

  localparam int unsigned SW     = SAMPLE_WIDTH;
  localparam int unsigned PROD_W = SW + CW;
  localparam int unsigned SUM_W  = PROD_W + 1;

  // configuration; grid width stored already clamped, with its fold point
  logic [CFG_W-1:0] depth_scale_q, phase_scale_q;
  logic [GW_W-1:0]  gw_q, half_q, gw_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    gw_d = cfg_data_i[GW_W-1:0];
    if (gw_d < GW_W'(2)) begin
      gw_d = GW_W'(2);
    end else if (gw_d > GW_W'(MAX_GRID_WIDTH)) begin
      gw_d = GW_W'(MAX_GRID_WIDTH);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_scale_q <= DEPTH_SCALE_RST;
      phase_scale_q <= PHASE_SCALE_RST;
      gw_q          <= GRID_WIDTH_RST;
      half_q        <= (GRID_WIDTH_RST >> 1) + GW_W'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_DEPTH_SCALE: depth_scale_q <= cfg_data_i;
        REG_PHASE_SCALE: phase_scale_q <= cfg_data_i;
        REG_GRID_WIDTH: begin
          gw_q   <= gw_d;
          half_q <= (gw_d >> 1) + GW_W'(1);
        end
        default: ;
      endcase
    end
  end

  // global advance: the output register is free or being taken
  logic en;
  logic out_vld_q;
  assign en         = !out_vld_q || !out_stall_i;
  assign in_stall_o = !en;

  // stage 1: fold wavenumber (frequency index already below MAX_FREQ_BINS)
  logic            v1_q;
  logic [K_W-1:0]  kf1_q, kf_d;
  logic [W_W-1:0]  w1_q;
  logic [SW-1:0]   sr1_q, si1_q;
  logic [GW_W-1:0] k_ext;

  always_comb begin
    k_ext = {1'b0, wavenumber_index_i};
    if (k_ext < half_q) begin
      kf_d = wavenumber_index_i;
    end else if (k_ext >= gw_q) begin
      kf_d = K_W'(k_ext - gw_q);
    end else begin
      kf_d = K_W'(gw_q - k_ext);
    end
  end

  // stage 2: squares
  logic             v2_q;
  logic [WSQ_W-1:0] wsq2_q;
  logic [KSQ_W-1:0] ksq2_q;
  logic [SW-1:0]    sr2_q, si2_q;

  // stage 3: argument terms
  logic             v3_q;
  logic [ARG_W-1:0] prod3_q, kk3_q;
  logic [SW-1:0]    sr3_q, si3_q;

  // stage 4: difference and evanescence flag
  logic             v4_q, ev4_q;
  logic [ARG_W-1:0] arg4_q;
  logic [SW-1:0]    sr4_q, si4_q;

  // full-width products
  logic [WSQ_W-1:0] wsq_d;
  logic [KSQ_W-1:0] ksq_d;
  logic [ARG_W-1:0] prod_d;

  assign wsq_d  = w1_q * w1_q;
  assign ksq_d  = kf1_q * kf1_q;
  assign prod_d = depth_scale_q * wsq2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kf1_q   <= kf_d;
      w1_q    <= frequency_index_i;
      sr1_q   <= sample_re_i;
      si1_q   <= sample_im_i;
      wsq2_q  <= wsq_d;
      ksq2_q  <= ksq_d;
      sr2_q   <= sr1_q;
      si2_q   <= si1_q;
      prod3_q <= prod_d;
      kk3_q   <= {{(ARG_W-KSQ_W-16){1'b0}}, ksq2_q, 16'd0};
      sr3_q   <= sr2_q;
      si3_q   <= si2_q;
      ev4_q   <= (prod3_q <= kk3_q);
      arg4_q  <= prod3_q - kk3_q;
      sr4_q   <= sr3_q;
      si4_q   <= si3_q;
    end
  end

  // square root
  logic              vr;
  logic [ROOT_W-1:0] root;
  logic [2*SW:0]     side_r;

  psds_sqrt #(
    .SIDE_W (2*SW+1)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v4_q),
    .arg_i   (arg4_q),
    .side_i  ({ev4_q, sr4_q, si4_q}),
    .valid_o (vr),
    .root_o  (root),
    .side_o  (side_r)
  );

  // phase = bits 39..8 of root * phase_scale
  logic                    vp_q;
  logic [ROOT_W+CFG_W-1:0] pprod;
  logic [PH_W-1:0]         phase_q;
  logic [2*SW:0]           side_p_q;

  assign pprod = root * phase_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (en) begin
      vp_q <= vr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      phase_q  <= pprod[PH_W+7:8];
      side_p_q <= side_r;
    end
  end

  logic                 vc;
  logic signed [CW-1:0] cosv, sinv;
  logic [2*SW:0]        side_c;

  psds_cordic #(
    .STAGES (CORDIC_STAGES),
    .SIDE_W (2*SW+1)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vp_q),
    .phase_i (phase_q),
    .side_i  (side_p_q),
    .valid_o (vc),
    .cos_o   (cosv),
    .sin_o   (sinv),
    .side_o  (side_c)
  );

  // complex multiply
  logic                     vm_q, evm_q;
  logic signed [PROD_W-1:0] rc_q, is_q, rs_q, ic_q;
  logic signed [PROD_W-1:0] rc_d, is_d, rs_d, ic_d;
  logic signed [SW-1:0]     src, sic;

  assign src = side_c[2*SW-1:SW];
  assign sic = side_c[SW-1:0];

  assign rc_d = src * cosv;
  assign is_d = sic * sinv;
  assign rs_d = src * sinv;
  assign ic_d = sic * cosv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else if (en) begin
      vm_q <= vc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rc_q  <= rc_d;
      is_q  <= is_d;
      rs_q  <= rs_d;
      ic_q  <= ic_d;
      evm_q <= side_c[2*SW];
    end
  end

  // round half up, saturate
  function automatic logic [SW-1:0] round_sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    logic signed [SUM_W-1:0] hi, lo;
    logic [SW-1:0]           o;
    hi = (SUM_W'(1) <<< (SW-1)) - SUM_W'(1);
    lo = -(SUM_W'(1) <<< (SW-1));
    r  = (v + SUM_W'(1 << (FRAC_SHIFT-1))) >>> FRAC_SHIFT;
    if (r > hi) begin
      o = hi[SW-1:0];
    end else if (r < lo) begin
      o = lo[SW-1:0];
    end else begin
      o = r[SW-1:0];
    end
    return o;
  endfunction

  logic signed [SUM_W-1:0] re_sum, im_sum;
  assign re_sum = SUM_W'(rc_q) - SUM_W'(is_q);
  assign im_sum = SUM_W'(rs_q) + SUM_W'(ic_q);

  logic [SW-1:0] re_q, im_q;
  logic          ev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      re_q <= evm_q ? '0 : round_sat(re_sum);
      im_q <= evm_q ? '0 : round_sat(im_sum);
      ev_q <= evm_q;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign result_re_o  = re_q;
  assign result_im_o  = im_q;
  assign evanescent_o = ev_q;

endmodule
`default_nettype wire

// ===== src/psds_sqrt.sv =====
// Pipelined floor integer square root, one result bit per register stage.
`default_nettype none
module psds_sqrt #(
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        valid_i,
  input  wire logic [psds_pkg::ARG_W-1:0]  arg_i,
  input  wire logic [SIDE_W-1:0]           side_i,
  output logic                             valid_o,
  output logic [psds_pkg::ROOT_W-1:0]      root_o,
  output logic [SIDE_W-1:0]                side_o
);
  import psds_pkg::*;

  logic [ROOT_W:1]             vld_q;
  logic [ROOT_W:1][ARG_W-1:0]  arg_q;
  logic [ROOT_W:1][REM_W-1:0]  rem_q;
  logic [ROOT_W:1][ROOT_W-1:0] root_q;
  logic [ROOT_W:1][SIDE_W-1:0] side_q;

  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    logic              vld_in;
    logic [ARG_W-1:0]  arg_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SIDE_W-1:0] side_in;
    logic [REM_W-1:0]  rem_sh, trial, rem_d;
    logic [ROOT_W-1:0] root_d;

    if (j == 0) begin : g_src
      assign vld_in  = valid_i;
      assign arg_in  = arg_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_src
      assign vld_in  = vld_q[j];
      assign arg_in  = arg_q[j];
      assign rem_in  = rem_q[j];
      assign root_in = root_q[j];
      assign side_in = side_q[j];
    end

    always_comb begin
      rem_sh = {rem_in[REM_W-3:0], arg_in[ARG_W-1-2*j -: 2]};
      trial  = {root_in, 2'b01};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_in[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[j+1] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        arg_q[j+1]  <= arg_in;
        rem_q[j+1]  <= rem_d;
        root_q[j+1] <= root_d;
        side_q[j+1] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[ROOT_W];
  assign root_o  = root_q[ROOT_W];
  assign side_o  = side_q[ROOT_W];

endmodule
`default_nettype wire

// ===== src/psds_cordic.sv =====
// Pipelined CORDIC cosine and sine of a Q0.32 turn phase, with quadrant fold.
`default_nettype none
module psds_cordic #(
  parameter int unsigned STAGES = psds_pkg::CORDIC_STAGES_DEF,
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        valid_i,
  input  wire logic [psds_pkg::PH_W-1:0]   phase_i,
  input  wire logic [SIDE_W-1:0]           side_i,
  output logic                             valid_o,
  output logic signed [psds_pkg::CW-1:0]   cos_o,
  output logic signed [psds_pkg::CW-1:0]   sin_o,
  output logic [SIDE_W-1:0]                side_o
);
  import psds_pkg::*;

  logic [STAGES:0]                  vld_q;
  logic signed [STAGES:0][CW-1:0]   x_q, y_q, z_q;
  logic [STAGES:0][1:0]             quad_q;
  logic [STAGES:0][SIDE_W-1:0]      side_q;

  // initial vector
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= CORDIC_GAIN;
      y_q[0]    <= '0;
      z_q[0]    <= {{(CW-PH_W+2){1'b0}}, phase_i[PH_W-3:0]};
      quad_q[0] <= phase_i[PH_W-1:PH_W-2];
      side_q[0] <= side_i;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [CW-1:0] dx, dy, rot, x_d, y_d, z_d;

    always_comb begin
      // elements of a packed array are unsigned; shift them as signed
      dx  = $signed(y_q[i]) >>> i;
      dy  = $signed(x_q[i]) >>> i;
      rot = {{(CW-PH_W){1'b0}}, rot_turn(i)};
      if (!z_q[i][CW-1]) begin
        x_d = x_q[i] - dx;
        y_d = y_q[i] + dy;
        z_d = z_q[i] - rot;
      end else begin
        x_d = x_q[i] + dx;
        y_d = y_q[i] - dy;
        z_d = z_q[i] + rot;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i+1]    <= x_d;
        y_q[i+1]    <= y_d;
        z_q[i+1]    <= z_d;
        quad_q[i+1] <= quad_q[i];
        side_q[i+1] <= side_q[i];
      end
    end
  end

  logic                 vld_out_q;
  logic signed [CW-1:0] cos_q, sin_q, cos_d, sin_d;
  logic [SIDE_W-1:0]    side_out_q;

  always_comb begin
    case (quad_q[STAGES])
      2'd0: begin
        cos_d = x_q[STAGES];
        sin_d = y_q[STAGES];
      end
      2'd1: begin
        cos_d = -y_q[STAGES];
        sin_d = x_q[STAGES];
      end
      2'd2: begin
        cos_d = -x_q[STAGES];
        sin_d = -y_q[STAGES];
      end
      default: begin
        cos_d = y_q[STAGES];
        sin_d = -x_q[STAGES];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else if (en_i) begin
      vld_out_q <= vld_q[STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q      <= cos_d;
      sin_q      <= sin_d;
      side_out_q <= side_q[STAGES];
    end
  end

  assign valid_o = vld_out_q;
  assign cos_o   = cos_q;
  assign sin_o   = sin_q;
  assign side_o  = side_out_q;

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the phase-shift depth step: directed and random samples.
`timescale 1ns / 1ps
module tb;
  import psds_pkg::*;

  localparam int unsigned LATENCY = 4 + 26 + 1 + (CORDIC_STAGES_DEF + 2) + 2;

  typedef struct packed {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               evan;
  } shifted_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [K_W-1:0] wavenumber_index_i = '0;
  logic [W_W-1:0] frequency_index_i = '0;
  logic signed [15:0] sample_re_i = '0;
  logic signed [15:0] sample_im_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] result_re_o;
  logic signed [15:0] result_im_o;
  logic evanescent_o;

  phase_shift_depth_step_top u_top (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor copy of the registers
  logic [31:0] depth_scale_q = DEPTH_SCALE_RST;
  logic [31:0] phase_scale_q = PHASE_SCALE_RST;
  logic [12:0] grid_width_q  = GRID_WIDTH_RST;

  shifted_t pending_shifts[$];
  int  errors = 0;
  int  n_sent = 0, n_evan = 0, n_prop = 0;
  bit  src_gaps = 1'b1, sink_gaps = 1'b1;

  function automatic longint fl_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic [15:0] round_clip(longint acc);
    longint v;
    v = fl_shr(acc + (64'sd1 <<< 29), 30);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic shifted_t predict_shift(logic [11:0] k, logic [9:0] w,
                                             logic signed [15:0] sr,
                                             logic signed [15:0] si);
    shifted_t o;
    longint unsigned gw, kf, kk, prod, root;
    logic [31:0] ph;
    longint x, y, z, dx, dy, c, s, t;
    gw = grid_width_q;
    if (gw < 2) gw = 2;
    if (gw > MAX_GRID_WIDTH) gw = MAX_GRID_WIDTH;
    if (k < gw / 2 + 1) kf = k;
    else kf = (k >= gw) ? k - gw : gw - k;
    kk = (kf * kf) << 16;
    prod = longint'(depth_scale_q) * (longint'(w) * longint'(w));
    if (prod <= kk) begin
      o.re = '0; o.im = '0; o.evan = 1'b1;
      return o;
    end
    root = isqrt(prod - kk);
    t = root * longint'(phase_scale_q);
    ph = t[39:8];
    x = 652032874; y = 0; z = ph[29:0];
    for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
      dx = fl_shr(y, i); dy = fl_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(rot_turn(i));
      end else begin
        x += dx; y -= dy; z += longint'(rot_turn(i));
      end
    end
    case (ph[31:30])
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    o.re = round_clip(longint'(sr) * c - longint'(si) * s);
    o.im = round_clip(longint'(sr) * s + longint'(si) * c);
    o.evan = 1'b0;
    return o;
  endfunction

  // result checker and output stall generator
  always @(posedge clk_i) begin
    shifted_t e;
    if (out_valid_o && !out_stall_i) begin
      if (pending_shifts.size() == 0) begin
        $error("result with no sample outstanding");
        errors++;
      end else begin
        e = pending_shifts.pop_front();
        if (result_re_o !== e.re) begin
          $error("result_re expected %0d got %0d", e.re, result_re_o); errors++;
        end
        if (result_im_o !== e.im) begin
          $error("result_im expected %0d got %0d", e.im, result_im_o); errors++;
        end
        if (evanescent_o !== e.evan) begin
          $error("evanescent expected %0d got %0d", e.evan, evanescent_o); errors++;
        end
      end
    end
  end

  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (sink_gaps && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 17);
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_DEPTH_SCALE: depth_scale_q = data;
      REG_PHASE_SCALE: phase_scale_q = data;
      REG_GRID_WIDTH:  grid_width_q  = data[12:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (pending_shifts.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // valid stays high between back-to-back transactions; gaps and drain_pipe drop it
  task automatic send_sample(logic [11:0] k, logic [9:0] w,
                             logic signed [15:0] sr, logic signed [15:0] si);
    if (src_gaps && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    wavenumber_index_i <= k;
    frequency_index_i  <= w;
    sample_re_i <= sr;
    sample_im_i <= si;
    do @(posedge clk_i); while (in_stall_o);
    pending_shifts.push_back(predict_shift(k, w, sr, si));
    n_sent++;
    if (pending_shifts[$].evan) n_evan++; else n_prop++;
  endtask

  task automatic test_directed();
    logic [15:0] ext[4] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF};
    write_reg(REG_PHASE_SCALE, 32'h0123_4567);
    // folding around the grid edge, beyond it, and evanescent/zero frequency
    foreach (ext[i]) send_sample(12'd0, 10'd1023, ext[i], ext[3-i]);
    send_sample(12'd128, 10'd200, 16'sh4000, -16'sh4000);
    send_sample(12'd129, 10'd200, 16'sh4000, 16'sh4000);
    send_sample(12'd255, 10'd1, 16'sh7FFF, 16'sh7FFF);
    send_sample(12'd256, 10'd1, 16'sh8000, 16'sh8000);
    send_sample(12'd4095, 10'd300, 16'sh1234, 16'shEDCB);
    send_sample(12'd5, 10'd0, 16'sh7FFF, 16'sh7FFF);
    send_sample(12'd1, 10'd1, 16'sh0100, 16'sh0100);
    send_sample(12'd2, 10'd1, 16'sh0100, 16'sh0100);
    drain_pipe();
    write_reg(REG_PHASE_SCALE, 32'h0);
    send_sample(12'd3, 10'd512, 16'sh7FFF, 16'sh8000);
    drain_pipe();
  endtask

  task automatic test_random_configs();
    logic [31:0] ds_set[5] = '{32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_0100, 32'h0}; 
    logic [12:0] gw_set[6] = '{13'd0, 13'd1, 13'd2, 13'd4096, 13'h1FFF, 13'd256};
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(REG_DEPTH_SCALE, ph < 5 ? ds_set[ph] : $urandom());
      write_reg(REG_PHASE_SCALE, ph == 1 ? 32'hFFFF_FFFF : $urandom());
      write_reg(REG_GRID_WIDTH, ph < 6 ? 32'(gw_set[ph]) : $urandom_range(2, 4096));
      if (ph == 9) begin
        src_gaps = 1'b0;
        sink_gaps = 1'b0;
        write_reg(IDX_W'(3), $urandom());
      end
      repeat (75) begin
        logic [11:0] k;
        k = ($urandom_range(0, 3) == 0) ? 12'($urandom())
                                        : 12'($urandom_range(0, grid_width_q > 2 ? grid_width_q / 4 : 2));
        send_sample(k, 10'($urandom()), 16'($urandom()), 16'($urandom()));
      end
      drain_pipe();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_configs();
    drain_pipe();
    $display("Sent %0d samples: %0d propagating, %0d evanescent,", n_sent, n_prop, n_evan);
    $display("covering directed fold and saturation cases plus ten random register sets.");
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
